/* src/deq_pkg.sv */
package deq_pkg;

  localparam int DEPTH = 16;
  localparam int DATA_W = 32;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int SUM_W = CNT_W + 1;

  localparam logic [2:0] CMD_NONE = 3'd0;
  localparam logic [2:0] CMD_PUSH_BACK = 3'd1;
  localparam logic [2:0] CMD_PUSH_FRONT = 3'd2;
  localparam logic [2:0] CMD_POP_BACK = 3'd3;
  localparam logic [2:0] CMD_POP_FRONT = 3'd4;
  localparam logic [2:0] CMD_CLEAR = 3'd5;

  localparam logic [1:0] ERR_OK = 2'd0;
  localparam logic [1:0] ERR_EMPTY = 2'd1;
  localparam logic [1:0] ERR_FULL = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_POP,
    ST_FRONT,
    ST_BACK,
    ST_RESULT
  } state_t;

endpackage

/* src/double_ended_queue_unit.sv */
// Bounded double-ended queue of 16 signed 32-bit values in a circular memory.
// Input channel (in_valid/in_ready) carries one beat per command: cmd selects
// none, push back, push front, pop back, pop front or clear, and push_value is
// the value stored by a push. Output channel (out_valid/out_ready) returns one
// beat per command: the popped value, the front and back values after the
// command, the element count and an error code (empty on a pop, full on a push).
// Each command steps through idle, pop, front, back and result. The accept
// cycle in idle performs any write and issues the read of the popped entry
// through the single registered read port of the memory; pop captures it and
// reads the front, front captures that and reads the back, and result loads
// the output register, back entry included. A new command is taken only in
// idle, so not before the previous one has left the result state.
// The output register holds a finished result while the receiver stalls; the
// next command is still accepted and runs until its own result is ready, then
// waits for the output register to drain.
// Synchronous reset empties the queue and resets the front pointer; memory
// contents are not cleared, since only written entries are ever reported.
module double_ended_queue_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  cmd,
  input  logic signed [31:0] push_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic signed [31:0] popped_value,
  output logic signed [31:0] front_value,
  output logic signed [31:0] back_value,
  output logic [4:0]  element_count,
  output logic [1:0]  error_code
);

  function automatic logic [deq_pkg::ADDR_W-1:0] slot(
    input logic [deq_pkg::ADDR_W-1:0] base,
    input logic [deq_pkg::CNT_W-1:0] offset
  );
    logic [deq_pkg::SUM_W-1:0] sum;
    sum = deq_pkg::SUM_W'(base) + deq_pkg::SUM_W'(offset);
    if (sum >= deq_pkg::SUM_W'(deq_pkg::DEPTH)) begin
      sum = sum - deq_pkg::SUM_W'(deq_pkg::DEPTH);
    end
    return sum[deq_pkg::ADDR_W-1:0];
  endfunction

  localparam logic [deq_pkg::CNT_W-1:0] FULL_COUNT = deq_pkg::CNT_W'(deq_pkg::DEPTH);
  localparam logic [deq_pkg::CNT_W-1:0] ONE = deq_pkg::CNT_W'(1);
  localparam logic [deq_pkg::CNT_W-1:0] LAST = deq_pkg::CNT_W'(deq_pkg::DEPTH - 1);

  logic [deq_pkg::DATA_W-1:0] mem [deq_pkg::DEPTH];
  logic [deq_pkg::DATA_W-1:0] mem_rdata;

  deq_pkg::state_t state, state_next;
  logic [deq_pkg::ADDR_W-1:0] front_ptr, front_ptr_next;
  logic [deq_pkg::CNT_W-1:0] count, count_next;
  logic pop_ok, pop_ok_next;
  logic [1:0] err, err_next;
  logic [deq_pkg::DATA_W-1:0] popped, front_val;

  logic accept, load_out, is_empty, is_full;
  logic mem_we;
  logic [deq_pkg::ADDR_W-1:0] mem_waddr, mem_raddr, back_addr, pop_addr;

  assign accept = in_valid && in_ready;
  assign is_empty = (count == '0);
  assign is_full = (count >= FULL_COUNT);
  assign back_addr = slot(front_ptr, count - ONE);

  always_comb begin
    state_next = state;
    case (state)
      deq_pkg::ST_IDLE: begin
        if (in_valid) state_next = deq_pkg::ST_POP;
      end
      deq_pkg::ST_POP: state_next = deq_pkg::ST_FRONT;
      deq_pkg::ST_FRONT: state_next = deq_pkg::ST_BACK;
      deq_pkg::ST_BACK: state_next = deq_pkg::ST_RESULT;
      deq_pkg::ST_RESULT: begin
        if (!out_valid || out_ready) state_next = deq_pkg::ST_IDLE;
      end
      default: state_next = deq_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    load_out = 1'b0;
    mem_raddr = front_ptr;
    case (state)
      deq_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        mem_raddr = pop_addr;
      end
      deq_pkg::ST_POP: mem_raddr = front_ptr;
      deq_pkg::ST_FRONT: mem_raddr = back_addr;
      deq_pkg::ST_BACK: mem_raddr = back_addr;
      deq_pkg::ST_RESULT: begin
        load_out = !out_valid || out_ready;
        mem_raddr = back_addr;
      end
      default: mem_raddr = front_ptr;
    endcase
  end

  always_comb begin
    front_ptr_next = front_ptr;
    count_next = count;
    err_next = deq_pkg::ERR_OK;
    pop_ok_next = 1'b0;
    mem_we = 1'b0;
    mem_waddr = back_addr;
    pop_addr = front_ptr;
    case (cmd)
      deq_pkg::CMD_PUSH_BACK: begin
        mem_waddr = slot(front_ptr, count);
        if (is_full) begin
          err_next = deq_pkg::ERR_FULL;
        end else begin
          mem_we = accept;
          count_next = count + ONE;
        end
      end
      deq_pkg::CMD_PUSH_FRONT: begin
        mem_waddr = slot(front_ptr, LAST);
        if (is_full) begin
          err_next = deq_pkg::ERR_FULL;
        end else begin
          mem_we = accept;
          front_ptr_next = mem_waddr;
          count_next = count + ONE;
        end
      end
      deq_pkg::CMD_POP_BACK: begin
        pop_addr = back_addr;
        if (is_empty) begin
          err_next = deq_pkg::ERR_EMPTY;
        end else begin
          pop_ok_next = 1'b1;
          count_next = count - ONE;
        end
      end
      deq_pkg::CMD_POP_FRONT: begin
        if (is_empty) begin
          err_next = deq_pkg::ERR_EMPTY;
        end else begin
          pop_ok_next = 1'b1;
          front_ptr_next = slot(front_ptr, ONE);
          count_next = count - ONE;
        end
      end
      deq_pkg::CMD_CLEAR: begin
        front_ptr_next = '0;
        count_next = '0;
      end
      default: begin
        count_next = count;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= push_value[deq_pkg::DATA_W-1:0];
    end
    mem_rdata <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= deq_pkg::ST_IDLE;
      front_ptr <= '0;
      count <= '0;
      pop_ok <= 1'b0;
      err <= deq_pkg::ERR_OK;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        front_ptr <= front_ptr_next;
        count <= count_next;
        pop_ok <= pop_ok_next;
        err <= err_next;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == deq_pkg::ST_POP) begin
      popped <= pop_ok ? mem_rdata : '0;
    end
    if (state == deq_pkg::ST_FRONT) begin
      front_val <= mem_rdata;
    end
    if (load_out) begin
      popped_value <= 32'(popped);
      front_value <= is_empty ? '0 : 32'(front_val);
      back_value <= is_empty ? '0 : 32'(mem_rdata);
      element_count <= 5'(count);
      error_code <= err;
    end
  end

  assert property (@(posedge clk) disable iff (rst) count <= FULL_COUNT)
    else $error("Element count exceeds the queue depth.");

  assert property (@(posedge clk) disable iff (rst)
    accept |=> !in_ready ##3 (state == deq_pkg::ST_RESULT))
    else $error("Command sequence did not reach the result state on time.");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && (element_count == 5'd0) |-> (front_value == '0) && (back_value == '0))
    else $error("Empty queue reported nonzero front or back value.");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && (error_code != deq_pkg::ERR_OK) |-> (popped_value == '0))
    else $error("Failed command reported a popped value.");

endmodule
